// ===== rtl/sdrp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrp_pkg
// Shared types and constants of the service definition record parser.
// ----------------------------------------------------------------------------
package sdrp_pkg;

	localparam int MAX_SERVICES = 64;
	localparam int ID_W         = 32;

	localparam logic [1:0] KIND_SERVICE   = 2'd0;
	localparam logic [1:0] KIND_COMPONENT = 2'd1;
	localparam logic [1:0] KIND_END       = 2'd2;

	typedef enum logic [3:0] {
		PH_ID     = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_COMP0  = 4'b0100,
		PH_COMP1  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       long_ids;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]      record_kind;
		logic [ID_W-1:0] service_id;
		logic [3:0]      country_id;
		logic [19:0]     service_ref;
		logic [7:0]      ext_country_code;
		logic [3:0]      count_or_index;
		logic [3:0]      service_flags;
		logic [1:0]      transport_mode;
		logic [5:0]      component_type;
		logic [5:0]      subchannel_id;
		logic [1:0]      component_flags;
		logic [3:0]      end_flags;
	} out_rec_t;

	typedef struct packed {
		logic insert;
		logic clear;
	} store_ctl_t;

endpackage

// ===== rtl/sdrp_cell.sv =====
// ----------------------------------------------------------------------------
// sdrp_cell
// One entry of the seen-id store: holds an id and its valid bit, takes its
// neighbor's entry on insert, and registers a compare against the key.
// ----------------------------------------------------------------------------
module sdrp_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sdrp_pkg::store_ctl_t      ctl,
	input  logic [sdrp_pkg::ID_W-1:0] key,
	input  logic [sdrp_pkg::ID_W-1:0] prev_id,
	input  logic                      prev_valid,
	output logic [sdrp_pkg::ID_W-1:0] id_q,
	output logic                      valid_q,
	output logic                      match_q
);
	import sdrp_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			id_q <= prev_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= valid_q && (id_q == key);
		end
	end

endmodule

// ===== rtl/sdrp_store.sv =====
// ----------------------------------------------------------------------------
// sdrp_store
// Seen-id store as a row of cells. New ids shift in at the head, so the
// valid entries always form a prefix and the last cell tells when it is full.
// ----------------------------------------------------------------------------
module sdrp_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sdrp_pkg::store_ctl_t      ctl,
	input  logic [sdrp_pkg::ID_W-1:0] key,
	output logic                      hit,
	output logic                      full
);
	import sdrp_pkg::*;

	logic [ID_W-1:0]         id_arr   [MAX_SERVICES];
	logic [ID_W-1:0]         prev_arr [MAX_SERVICES];
	logic [MAX_SERVICES-1:0] valid_vec;
	logic [MAX_SERVICES-1:0] prev_vec;
	logic [MAX_SERVICES-1:0] match_vec;

	for (genvar i = 0; i < MAX_SERVICES; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_arr[i] = key;
			assign prev_vec[i] = 1'b1;
		end else begin : g_body
			assign prev_arr[i] = id_arr[i-1];
			assign prev_vec[i] = valid_vec[i-1];
		end

		sdrp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key),
			.prev_id    (prev_arr[i]),
			.prev_valid (prev_vec[i]),
			.id_q       (id_arr[i]),
			.valid_q    (valid_vec[i]),
			.match_q    (match_vec[i])
		);
	end

	assign hit  = |match_vec;
	assign full = valid_vec[MAX_SERVICES-1];

endmodule

// ===== rtl/service_definition_record_parser_top.sv =====
// ----------------------------------------------------------------------------
// service_definition_record_parser_top
// Parses a service definition record list byte by byte into service and
// component records, tracking repetition through a store of seen ids.
// ----------------------------------------------------------------------------
// Each accepted byte passes a compare stage, in which every store cell
// registers its compare against the assembled service id, and a commit
// stage, in which the parser commits its state, updates the store and loads
// the output register. A byte is accepted in the cycle its predecessor
// commits, so a new byte is never taken before the last one has committed;
// a stalled output holds only the byte waiting to commit. The store keeps
// up to MAX_SERVICES ids; it needs no clearing pass after reset.
module service_definition_record_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  sdrp_pkg::in_item_t byte_data,
	output logic               rec_valid,
	input  logic               rec_stall,
	output sdrp_pkg::out_rec_t rec_data
);
	import sdrp_pkg::*;

	logic       valid_s1, valid_s2;
	in_item_t   item_s1, item_s2;

	phase_t     phase_q, phase_n;
	logic [1:0] cnt_q, cnt_n;
	logic [31:0] acc_q, acc_n;
	logic [3:0] left_q, left_n;
	logic [3:0] index_q, index_n;
	logic [7:0] held_q, held_n;
	logic       repeat_q, repeat_n;
	logic       wide_q, wide_n;

	logic       rec_valid_q;
	out_rec_t   rec_q;

	out_rec_t   res;
	logic       has_result;
	logic       commit;
	logic       accept;
	store_ctl_t ctl, store_ctl;
	logic       hit, full;
	logic [7:0] b;

	logic [3:0]  svc_country;
	logic [19:0] svc_ref;
	logic [7:0]  svc_ecc;

	sdrp_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (store_ctl),
		.key    (acc_q),
		.hit    (hit),
		.full   (full)
	);

	always_comb begin
		if (wide_q) begin
			svc_country = acc_q[23:20];
			svc_ref     = acc_q[19:0];
			svc_ecc     = acc_q[31:24];
		end else begin
			svc_country = acc_q[15:12];
			svc_ref     = {8'd0, acc_q[11:0]};
			svc_ecc     = 8'd0;
		end
	end

	assign b = item_s2.data_byte;

	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		acc_n      = acc_q;
		left_n     = left_q;
		index_n    = index_q;
		held_n     = held_q;
		repeat_n   = repeat_q;
		wide_n     = wide_q;
		res        = '0;
		has_result = 1'b0;
		ctl        = '0;

		case (phase_q)
			PH_ID: begin
				if (cnt_q == 2'd0) begin
					wide_n = item_s2.long_ids;
					acc_n  = {24'd0, b};
				end else begin
					acc_n = {acc_q[23:0], b};
				end
				if (wide_n ? (cnt_q == 2'd3) : (cnt_q != 2'd0)) begin
					cnt_n   = 2'd0;
					phase_n = PH_HEADER;
				end else begin
					cnt_n = cnt_q + 2'd1;
				end
			end
			PH_HEADER: begin
				ctl.clear  = hit;
				ctl.insert = !hit && !full;
				repeat_n   = repeat_q | hit;
				res.record_kind      = KIND_SERVICE;
				res.service_id       = acc_q;
				res.country_id       = svc_country;
				res.service_ref      = svc_ref;
				res.ext_country_code = svc_ecc;
				res.count_or_index   = b[3:0];
				res.service_flags    = b[7:4];
				res.end_flags[3]     = !hit && full;
				has_result = 1'b1;
				left_n     = b[3:0];
				index_n    = 4'd0;
				phase_n    = (b[3:0] != 4'd0) ? PH_COMP0 : PH_ID;
			end
			PH_COMP0: begin
				held_n  = b;
				phase_n = PH_COMP1;
			end
			PH_COMP1: begin
				res.record_kind      = KIND_COMPONENT;
				res.service_id       = acc_q;
				res.country_id       = svc_country;
				res.service_ref      = svc_ref;
				res.ext_country_code = svc_ecc;
				res.count_or_index   = index_q;
				res.transport_mode   = held_q[7:6];
				res.component_type   = held_q[5:0];
				res.subchannel_id    = b[7:2];
				res.component_flags  = b[1:0];
				has_result = 1'b1;
				index_n    = index_q + 4'd1;
				left_n     = left_q - 4'd1;
				phase_n    = (left_q != 4'd1) ? PH_COMP0 : PH_ID;
			end
			default: begin
				phase_n = PH_ID;
			end
		endcase

		res.end_flags[1] = repeat_n;

		if (item_s2.last_byte) begin
			res.end_flags[0] = 1'b1;
			res.end_flags[2] = (phase_n != PH_ID) || (cnt_n != 2'd0);
			if (!has_result) begin
				res.record_kind = KIND_END;
				has_result      = 1'b1;
			end
			// drop all per-list state; the store is kept
			phase_n  = PH_ID;
			cnt_n    = 2'd0;
			acc_n    = 32'd0;
			left_n   = 4'd0;
			index_n  = 4'd0;
			held_n   = 8'd0;
			repeat_n = 1'b0;
			wide_n   = 1'b0;
		end
	end

	assign commit     = valid_s2 && (!has_result || !rec_valid_q || !rec_stall);
	assign byte_stall = valid_s1 || (valid_s2 && !commit);
	assign accept     = byte_valid && !byte_stall;
	assign store_ctl  = commit ? ctl : '0;

	// stage 1 lets the store cells register their compares before the parser uses them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (commit) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_data;
		end
		if (valid_s1) begin
			item_s2 <= item_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ID;
			cnt_q    <= 2'd0;
			acc_q    <= 32'd0;
			left_q   <= 4'd0;
			index_q  <= 4'd0;
			held_q   <= 8'd0;
			repeat_q <= 1'b0;
			wide_q   <= 1'b0;
		end else if (commit) begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			acc_q    <= acc_n;
			left_q   <= left_n;
			index_q  <= index_n;
			held_q   <= held_n;
			repeat_q <= repeat_n;
			wide_q   <= wide_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (commit && has_result) begin
			rec_valid_q <= 1'b1;
		end else if (!rec_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && has_result) begin
			rec_q <= res;
		end
	end

	assign rec_valid = rec_valid_q;
	assign rec_data  = rec_q;

	a_stage_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("both pipeline stages hold a byte");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		store_ctl.clear |=> !full)
		else $error("store still full after clear");

	a_end_notice: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_data.record_kind == KIND_END)
			|-> (rec_data.end_flags[0] && rec_data.end_flags[2]))
		else $error("end-only notice without end and truncated flags");

	a_count_in_id: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_ID) |-> (cnt_q == 2'd0))
		else $error("id byte count left over outside id phase");

endmodule

// ===== tb/service_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_record_checker
// Follows the parse of every body byte that the record parser accepts, keeps
// the records each byte is due to produce, and compares every record the
// parser delivers, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module service_record_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  sdrp_pkg::in_item_t byte_data,
	input  logic               rec_valid,
	input  logic               rec_stall,
	input  sdrp_pkg::out_rec_t rec_data,
	output int                 pending,
	output int                 mismatch_count
);
	import sdrp_pkg::*;

	// bit positions inside end_flags
	localparam int EF_END    = 0;
	localparam int EF_REPEAT = 1;
	localparam int EF_TRUNC  = 2;
	localparam int EF_DROP   = 3;

	phase_t                  list_phase;
	logic [1:0]              id_count;
	logic [31:0]             id_acc;
	logic [3:0]              comps_owed;
	logic [3:0]              comp_index;
	logic [7:0]              held_byte;
	logic                    repeat_flag;
	logic                    wide_ids;
	logic [31:0]             seen_id [MAX_SERVICES];
	logic [MAX_SERVICES-1:0] seen_ok;

	out_rec_t expected_records[$];

	task automatic restart_list();
		list_phase  = PH_ID;
		id_count    = '0;
		id_acc      = '0;
		comps_owed  = '0;
		comp_index  = '0;
		held_byte   = '0;
		repeat_flag = 1'b0;
		wide_ids    = 1'b0;
	endtask

	// Returns 1 when the id had to be dropped because every slot is taken.
	function automatic bit store_id(input logic [31:0] id);
		int i;
		int free_slot;
		free_slot = -1;
		for (i = 0; i < MAX_SERVICES; i++) begin
			if (seen_ok[i] && seen_id[i] == id) begin
				// database repeats: forget everything seen so far
				seen_ok     = '0;
				repeat_flag = 1'b1;
				return 1'b0;
			end
			if (!seen_ok[i] && free_slot < 0)
				free_slot = i;
		end
		if (free_slot < 0)
			return 1'b1;
		seen_id[free_slot] = id;
		seen_ok[free_slot] = 1'b1;
		return 1'b0;
	endfunction

	function automatic out_rec_t service_fields();
		out_rec_t r;
		r = '0;
		r.service_id = id_acc;
		if (wide_ids) begin
			r.country_id       = id_acc[23:20];
			r.service_ref      = id_acc[19:0];
			r.ext_country_code = id_acc[31:24];
		end else begin
			r.country_id  = id_acc[15:12];
			r.service_ref = {8'h00, id_acc[11:0]};
		end
		return r;
	endfunction

	task automatic parse_body_byte(input in_item_t it, output bit emit, output out_rec_t rec);
		logic [3:0] flags;
		int         need;
		emit  = 1'b0;
		rec   = '0;
		flags = '0;
		case (list_phase)
			PH_ID: begin
				// the width is latched on the first byte of each id
				if (id_count == 2'd0) begin
					wide_ids = it.long_ids;
					id_acc   = {24'h0, it.data_byte};
				end else begin
					id_acc = {id_acc[23:0], it.data_byte};
				end
				need = wide_ids ? 4 : 2;
				if (int'(id_count) + 1 >= need) begin
					id_count   = '0;
					list_phase = PH_HEADER;
				end else begin
					id_count = id_count + 2'd1;
				end
			end
			PH_HEADER: begin
				flags[EF_DROP]     = store_id(id_acc);
				rec                = service_fields();
				rec.record_kind    = KIND_SERVICE;
				rec.count_or_index = it.data_byte[3:0];
				rec.service_flags  = it.data_byte[7:4];
				comps_owed         = it.data_byte[3:0];
				comp_index         = '0;
				list_phase         = (comps_owed != 4'd0) ? PH_COMP0 : PH_ID;
				emit               = 1'b1;
			end
			PH_COMP0: begin
				held_byte  = it.data_byte;
				list_phase = PH_COMP1;
			end
			default: begin
				rec                 = service_fields();
				rec.record_kind     = KIND_COMPONENT;
				rec.count_or_index  = comp_index;
				rec.transport_mode  = held_byte[7:6];
				rec.component_type  = held_byte[5:0];
				rec.subchannel_id   = it.data_byte[7:2];
				rec.component_flags = it.data_byte[1:0];
				comp_index          = comp_index + 4'd1;
				comps_owed          = comps_owed - 4'd1;
				list_phase          = (comps_owed != 4'd0) ? PH_COMP0 : PH_ID;
				emit                = 1'b1;
			end
		endcase
		flags[EF_REPEAT] = repeat_flag;
		if (it.last_byte) begin
			flags[EF_END]   = 1'b1;
			flags[EF_TRUNC] = (list_phase != PH_ID) || (id_count != 2'd0);
			if (!emit) begin
				rec.record_kind = KIND_END;
				emit            = 1'b1;
			end
			restart_list();
		end
		rec.end_flags = flags;
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, %0h expected", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_rec_t want;
		out_rec_t due;
		bit       emit;
		if (!arst_n) begin
			restart_list();
			seen_ok = '0;
			expected_records.delete();
			mismatch_count = 0;
			pending <= 0;
		end else begin
			// a record taken at this edge cannot come from a byte taken at it
			if (rec_valid && !rec_stall) begin
				if (expected_records.size() == 0) begin
					report_mismatch("record delivered with none due");
				end else begin
					want = expected_records.pop_front();
					check_field("record_kind", 32'(rec_data.record_kind),
						32'(want.record_kind));
					check_field("service_id", rec_data.service_id, want.service_id);
					check_field("country_id", 32'(rec_data.country_id),
						32'(want.country_id));
					check_field("service_ref", 32'(rec_data.service_ref),
						32'(want.service_ref));
					check_field("ext_country_code", 32'(rec_data.ext_country_code),
						32'(want.ext_country_code));
					check_field("count_or_index", 32'(rec_data.count_or_index),
						32'(want.count_or_index));
					check_field("service_flags", 32'(rec_data.service_flags),
						32'(want.service_flags));
					check_field("transport_mode", 32'(rec_data.transport_mode),
						32'(want.transport_mode));
					check_field("component_type", 32'(rec_data.component_type),
						32'(want.component_type));
					check_field("subchannel_id", 32'(rec_data.subchannel_id),
						32'(want.subchannel_id));
					check_field("component_flags", 32'(rec_data.component_flags),
						32'(want.component_flags));
					check_field("end_flags", 32'(rec_data.end_flags),
						32'(want.end_flags));
				end
			end
			if (byte_valid && !byte_stall) begin
				parse_body_byte(byte_data, emit, due);
				if (emit)
					expected_records.push_back(due);
			end
			pending <= expected_records.size();
		end
	end

endmodule

// ===== tb/service_definition_record_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// service_definition_record_parser_top_tb
// Feeds the record parser directed record lists, a long run of distinct ids
// that overflows the seen-id store, and random well-formed, cut-short and
// garbage lists, with random gaps and stalls on both channels. A checker
// beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module service_definition_record_parser_top_tb;
	import sdrp_pkg::*;

	localparam int ITEMS         = 550;
	localparam int HOLD_CYCLES   = 200;
	localparam int FILL_SERVICES = 70;
	localparam int HISTORY_DEPTH = 40;
	localparam int HOLD_AT_ITEM  = 350;

	logic     clk        = 1'b0;
	logic     arst_n     = 1'b0;
	logic     byte_valid = 1'b0;
	logic     byte_stall;
	in_item_t byte_data  = '0;
	logic     rec_valid;
	logic     rec_stall  = 1'b0;
	out_rec_t rec_data;

	int pending;
	int mismatch_count;

	in_item_t    list_bytes[$];
	logic [32:0] used_ids[$];
	int          sent_count   = 0;
	int          gap_mode     = 0;
	logic        hold_request = 1'b0;
	bit          hold_done    = 1'b0;
	int          hold_left    = 0;
	int          stall_left   = 0;
	int          free_left    = 0;

	service_definition_record_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_data   (rec_data)
	);

	service_record_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_stall     (byte_stall),
		.byte_data      (byte_data),
		.rec_valid      (rec_valid),
		.rec_stall      (rec_stall),
		.rec_data       (rec_data),
		.pending        (pending),
		.mismatch_count (mismatch_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("service_definition_record_parser_top_tb: errors");
		$finish;
	end

	// mostly short, now and then long
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	function automatic int sender_gap();
		if (gap_mode == 0)
			return 0;
		if (gap_mode == 1 && $urandom_range(0, 1) == 0)
			return 0;
		return random_gap();
	endfunction

	// record sink: random stalls, calm stretches, and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			rec_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
			rec_stall <= 1'b1;
		end else if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			rec_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			rec_stall <= 1'b1;
		end else if (free_left != 0) begin
			free_left = free_left - 1;
			rec_stall <= 1'b0;
		end else begin
			rec_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0) begin
				free_left = $urandom_range(20, 100);
			end else begin
				stall_left = random_gap();
				free_left  = $urandom_range(0, 3);
			end
		end
	end

	task automatic send_byte(input in_item_t it);
		int gap;
		byte_data  <= it;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		sent_count++;
		gap = sender_gap();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every record due has been delivered
	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b, input bit wide);
		in_item_t it;
		it.data_byte = b;
		it.long_ids  = wide;
		it.last_byte = 1'b0;
		list_bytes.push_back(it);
	endtask

	// id MSB first, header, then two random bytes per component
	task automatic add_service(input logic [31:0] id, input bit wide, input logic [7:0] header);
		int k;
		int top_byte;
		top_byte = wide ? 3 : 1;
		for (k = top_byte; k >= 0; k--)
			add_byte(id[8*k +: 8], (k == top_byte) ? wide : 1'($urandom));
		add_byte(header, 1'($urandom));
		repeat (header[3:0]) begin
			add_byte(8'($urandom), 1'($urandom));
			add_byte(8'($urandom), 1'($urandom));
		end
	endtask

	task automatic remember_id(input bit wide, input logic [31:0] id);
		used_ids.push_back({wide, id});
		if (used_ids.size() > HISTORY_DEPTH)
			void'(used_ids.pop_front());
	endtask

	// send the built list up to and including cut, marking that byte last
	task automatic send_list(input int cut);
		int       k;
		in_item_t it;
		gap_mode = $urandom_range(0, 2);
		if (cut < 0 || cut >= list_bytes.size())
			cut = list_bytes.size() - 1;
		for (k = 0; k <= cut; k++) begin
			it           = list_bytes[k];
			it.last_byte = (k == cut);
			send_byte(it);
		end
		list_bytes.delete();
	endtask

	initial begin
		int          k;
		int          cut;
		int          nsvc;
		int          ncomp;
		bit          wide;
		logic [31:0] id;
		logic [32:0] pick;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short id at the top of its range, all service flags set, one
		// component of all ones and one of all zeros; long_ids flips mid-id
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_byte(8'hF2, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		send_list(-1);
		// long id of zero, no components, list ends on the header
		add_byte(8'h00, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'h80, 1'b0);
		send_list(-1);
		// same short id again clears the store; list ends with a component owed
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h01, 1'b0);
		send_list(-1);
		// list ends inside an id
		add_byte(8'hA5, 1'b1);
		send_list(-1);
		// list ends on half a component
		add_byte(8'h12, 1'b0);
		add_byte(8'h34, 1'b0);
		add_byte(8'h11, 1'b0);
		add_byte(8'hC3, 1'b0);
		send_list(-1);
		// list ends with the header still missing
		add_byte(8'h56, 1'b0);
		add_byte(8'h78, 1'b0);
		send_list(-1);
		drain();

		// distinct ids until the store overflows and drops the rest
		for (k = 0; k < FILL_SERVICES; k++) begin
			id = {16'h0000, 8'(8'h20 + k), 8'($urandom)};
			add_service(id, 1'b0, {4'($urandom), 4'h0});
			remember_id(1'b0, id);
		end
		send_list(-1);

		while (sent_count < ITEMS) begin
			if (!hold_request && sent_count >= HOLD_AT_ITEM)
				hold_request <= 1'b1;
			if ($urandom_range(0, 11) == 0) begin
				// garbage bytes
				repeat ($urandom_range(1, 6))
					add_byte(8'($urandom), 1'($urandom));
				send_list(-1);
			end else begin
				nsvc = $urandom_range(1, 3);
				repeat (nsvc) begin
					wide = 1'($urandom);
					id   = wide ? 32'($urandom) : {16'h0000, 16'($urandom)};
					if (used_ids.size() != 0 && $urandom_range(0, 4) == 0) begin
						pick = used_ids[$urandom_range(0, used_ids.size() - 1)];
						wide = pick[32];
						id   = pick[31:0];
					end
					if ($urandom_range(0, 19) == 0)
						ncomp = 15;
					else
						ncomp = $urandom_range(0, 3);
					add_service(id, wide, {4'($urandom), 4'(ncomp)});
					remember_id(wide, id);
				end
				// some lists stop early
				if ($urandom_range(0, 7) == 0)
					cut = $urandom_range(0, list_bytes.size() - 2);
				else
					cut = -1;
				send_list(cut);
			end
			if ($urandom_range(0, 24) == 0)
				drain();
		end

		drain();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("service_definition_record_parser_top_tb: clean");
		else
			$display("service_definition_record_parser_top_tb: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sdrp_pkg.sv
rtl/sdrp_cell.sv
rtl/sdrp_store.sv
rtl/service_definition_record_parser_top.sv
tb/service_record_checker.sv
tb/service_definition_record_parser_top_tb.sv
